// ----- rtl/smoothed_progress_rate_estimator_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the progress rate estimator.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_PROGRESS_RATE_ESTIMATOR_MACROS_SVH
`define SMOOTHED_PROGRESS_RATE_ESTIMATOR_MACROS_SVH

// same-cycle implication
`define SPRE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spre assertion failed");

// next-cycle implication
`define SPRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spre assertion failed");

`endif

// ----- rtl/spre_pkg.sv -----
// ----------------------------------------------------------------------------
// spre_pkg
// Types and constants shared by the progress rate estimator modules.
// ----------------------------------------------------------------------------
package spre_pkg;

	localparam int TIME_W      = 48;
	localparam int ETA_W       = 32;
	localparam int ALPHA_W     = 17;
	localparam int RATE_W      = 32;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
	localparam int DIV_STEPS   = 48;
	localparam int STEP_W      = $clog2(DIV_STEPS);

	typedef struct packed {
		logic capture;
		logic mul;
		logic update;
		logic prep;
		logic div_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic ring_full;
		logic den_bad;
		logic out_free;
	} status_t;

endpackage

// ----- rtl/spre_sample_if.sv -----
// ----------------------------------------------------------------------------
// spre_sample_if
// Input channel: timestamped time-to-goal estimate.
// ----------------------------------------------------------------------------
interface spre_sample_if;
	logic                        valid;
	logic                        ready;
	logic [spre_pkg::TIME_W-1:0] sample_time;
	logic [spre_pkg::ETA_W-1:0]  eta_value;

	modport source (output valid, output sample_time, output eta_value, input ready);
	modport sink   (input valid, input sample_time, input eta_value, output ready);
endinterface

// ----- rtl/spre_result_if.sv -----
// ----------------------------------------------------------------------------
// spre_result_if
// Output channel: filtered estimate and progress rate.
// ----------------------------------------------------------------------------
interface spre_result_if;
	logic                              valid;
	logic                              ready;
	logic                              filtered_valid;
	logic [spre_pkg::ETA_W-1:0]        smooth_eta;
	logic                              rate_valid;
	logic signed [spre_pkg::RATE_W-1:0] rate_value;
	logic                              rate_error;

	modport source (output valid, output filtered_valid, output smooth_eta,
		output rate_valid, output rate_value, output rate_error, input ready);
	modport sink   (input valid, input filtered_valid, input smooth_eta,
		input rate_valid, input rate_value, input rate_error, output ready);
endinterface

// ----- rtl/spre_dpath.sv -----
// ----------------------------------------------------------------------------
// spre_dpath
// Filter, sample ring, restoring divider and output register.
// ----------------------------------------------------------------------------
module spre_dpath #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  spre_pkg::cmd_t                      cmd,
	output spre_pkg::status_t                   stat,
	input  logic                                in_valid,
	input  logic                                cfg_wr_en,
	input  logic [spre_pkg::ALPHA_W-1:0]        cfg_wr_data,
	input  logic [spre_pkg::TIME_W-1:0]         sample_time,
	input  logic [spre_pkg::ETA_W-1:0]          eta_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                filtered_valid,
	output logic [spre_pkg::ETA_W-1:0]          smooth_eta,
	output logic                                rate_valid,
	output logic signed [spre_pkg::RATE_W-1:0]  rate_value,
	output logic                                rate_error
);

	localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);
	localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW_DEPTH - 1);

	logic [spre_pkg::TIME_W-1:0] time_mem [WINDOW_DEPTH];
	logic [spre_pkg::ETA_W-1:0]  filt_mem [WINDOW_DEPTH];

	logic [spre_pkg::ALPHA_W-1:0] alpha_q;
	logic [spre_pkg::ETA_W-1:0]   ema_q;
	logic [FILL_W-1:0]            fill_q;
	logic [PTR_W-1:0]             wr_ptr_q;
	logic                         out_valid_q;

	logic                               filtered_valid_q;
	logic [spre_pkg::ETA_W-1:0]         smooth_eta_q;
	logic                               rate_valid_q;
	logic signed [spre_pkg::RATE_W-1:0] rate_value_q;
	logic                               rate_error_q;

	logic [spre_pkg::TIME_W-1:0]  t_q;
	logic [spre_pkg::ETA_W-1:0]   x_q;
	logic [spre_pkg::TIME_W-1:0]  old_time_q;
	logic [spre_pkg::ETA_W-1:0]   old_filt_q;
	logic signed [50:0]           prod_q;
	logic [spre_pkg::ETA_W-1:0]   f_q;
	logic signed [48:0]           den_q;
	logic                         neg_q;
	logic [47:0]                  rem_q;
	logic [47:0]                  quo_q;
	logic [47:0]                  dvsr_q;

	logic                         seed;
	logic                         ring_full;
	logic                         den_bad;
	logic signed [17:0]           alpha_s;
	logic signed [32:0]           diff_s;
	logic signed [50:0]           prod_d;
	logic signed [35:0]           sum_d;
	logic [spre_pkg::ETA_W-1:0]   f_clamp;
	logic signed [48:0]           den_d;
	logic signed [32:0]           num_d;
	logic [32:0]                  mag_d;
	logic [48:0]                  shifted;
	logic [48:0]                  trial;
	logic                         ge;
	logic                         pos_ovf;
	logic                         neg_ovf;
	logic [spre_pkg::RATE_W-1:0]  rate_sat;
	logic [spre_pkg::ETA_W-1:0]   commit_f;

	assign seed      = (fill_q == '0);
	assign ring_full = (fill_q == FILL_FULL);
	assign den_bad   = den_q[48] || (den_q == '0);

	assign alpha_s = signed'({1'b0, alpha_q});
	assign diff_s  = signed'({1'b0, x_q}) - signed'({1'b0, ema_q});
	assign prod_d  = alpha_s * diff_s;
	assign sum_d   = signed'({4'b0, ema_q}) + signed'({prod_q[50], prod_q[50:16]});

	always_comb begin
		if (sum_d[35]) begin
			f_clamp = '0;
		end else if (|sum_d[34:32]) begin
			f_clamp = '1;
		end else begin
			f_clamp = sum_d[31:0];
		end
	end

	assign den_d = signed'({1'b0, t_q}) - signed'({1'b0, old_time_q});
	assign num_d = signed'({1'b0, old_filt_q}) - signed'({1'b0, f_q});
	assign mag_d = num_d[32] ? 33'(-num_d) : 33'(num_d);

	assign shifted = {rem_q, quo_q[47]};
	assign ge      = (shifted >= {1'b0, dvsr_q});
	assign trial   = shifted - {1'b0, dvsr_q};

	assign pos_ovf = |quo_q[47:31];
	assign neg_ovf = (|quo_q[47:32]) || (quo_q[31] && (|quo_q[30:0]));

	always_comb begin
		if (neg_q) begin
			rate_sat = neg_ovf ? 32'h8000_0000 : (~quo_q[31:0] + 32'd1);
		end else begin
			rate_sat = pos_ovf ? 32'h7fff_ffff : quo_q[31:0];
		end
	end

	assign commit_f = seed ? x_q : f_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= spre_pkg::ALPHA_RESET;
			ema_q       <= '0;
			fill_q      <= '0;
			wr_ptr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				alpha_q <= cfg_wr_data;
			end
			if (cmd.commit) begin
				ema_q       <= commit_f;
				wr_ptr_q    <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
				out_valid_q <= 1'b1;
				if (!ring_full) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			t_q        <= sample_time;
			x_q        <= eta_value;
			old_time_q <= time_mem[wr_ptr_q];
			old_filt_q <= filt_mem[wr_ptr_q];
		end
		if (cmd.commit) begin
			time_mem[wr_ptr_q] <= t_q;
			filt_mem[wr_ptr_q] <= commit_f;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= prod_d;
			den_q  <= den_d;
		end
		if (cmd.update) begin
			f_q <= f_clamp;
		end
		if (cmd.prep) begin
			neg_q  <= num_d[32];
			quo_q  <= {mag_d[31:0], 16'b0};
			rem_q  <= '0;
			dvsr_q <= den_q[47:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial[47:0] : shifted[47:0];
			quo_q <= {quo_q[46:0], ge};
		end
		if (cmd.commit) begin
			filtered_valid_q <= !seed;
			smooth_eta_q     <= seed ? '0 : f_q;
			rate_valid_q     <= ring_full;
			rate_error_q     <= ring_full && den_bad;
			rate_value_q     <= (ring_full && !den_bad) ? signed'(rate_sat) : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_valid = filtered_valid_q;
	assign smooth_eta     = smooth_eta_q;
	assign rate_valid     = rate_valid_q;
	assign rate_value     = rate_value_q;
	assign rate_error     = rate_error_q;
	assign stat.in_valid  = in_valid;
	assign stat.ring_full = ring_full;
	assign stat.den_bad   = den_bad;
	assign stat.out_free  = !out_valid_q || out_ready;

endmodule

// ----- rtl/spre_ctrl.sv -----
// ----------------------------------------------------------------------------
// spre_ctrl
// Sequencer for filter update, rate divide and result hand-off.
// ----------------------------------------------------------------------------
`include "smoothed_progress_rate_estimator_macros.svh"

module spre_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  spre_pkg::status_t stat,
	output spre_pkg::cmd_t    cmd,
	output logic              in_ready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_PREP,
		ST_DIV,
		ST_COMMIT
	} state_t;

	localparam logic [spre_pkg::STEP_W-1:0] STEP_LAST =
		spre_pkg::STEP_W'(spre_pkg::DIV_STEPS - 1);

	state_t                      state_q;
	logic [spre_pkg::STEP_W-1:0] step_q;
	logic                        div_go;
	logic                        div_last;
	logic                        commit_wait;

	assign div_go      = stat.ring_full && !stat.den_bad;
	assign div_last    = (step_q == STEP_LAST);
	assign commit_wait = (state_q == ST_COMMIT) && !stat.out_free;

	always_comb begin
		cmd.capture  = (state_q == ST_IDLE) && stat.in_valid;
		cmd.mul      = (state_q == ST_MUL);
		cmd.update   = (state_q == ST_UPD);
		cmd.prep     = (state_q == ST_PREP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.commit   = (state_q == ST_COMMIT) && stat.out_free;
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (stat.in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= div_go ? ST_PREP : ST_COMMIT;
				end
				ST_PREP: begin
					state_q <= ST_DIV;
					step_q  <= '0;
				end
				ST_DIV: begin
					if (div_last) begin
						state_q <= ST_COMMIT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_COMMIT: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SPRE_ASSERT_NEXT(a_accept_starts, clk, arst_n, cmd.capture, state_q == ST_MUL)
	`SPRE_ASSERT_NEXT(a_div_len, clk, arst_n, (state_q == ST_DIV) && div_last, state_q == ST_COMMIT)
	`SPRE_ASSERT_NEXT(a_rate_path, clk, arst_n, (state_q == ST_UPD) && div_go, state_q == ST_PREP)
	`SPRE_ASSERT_NEXT(a_commit_stall, clk, arst_n, commit_wait, state_q == ST_COMMIT)

endmodule

// ----- rtl/smoothed_progress_rate_estimator.sv -----
// ----------------------------------------------------------------------------
// smoothed_progress_rate_estimator
// Exponential filter on time-to-goal estimates with windowed rate output.
// ----------------------------------------------------------------------------
// One sample is in flight at a time. A sample that fills or seeds the ring
// passes through accept, multiply, filter update and commit; once the ring
// is full and the time step is positive it passes through accept, multiply,
// filter update, divider setup, 48 restoring divide steps and commit, the
// 48-bit divider giving one quotient bit per cycle. A zero or negative time
// step skips the divide. The result sits in an output register, so the next
// sample is accepted while the previous result still waits to be taken.
module smoothed_progress_rate_estimator #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [spre_pkg::ALPHA_W-1:0] cfg_wr_data,
	spre_sample_if.sink                  samples,
	spre_result_if.source                results
);

	spre_pkg::cmd_t    cmd;
	spre_pkg::status_t stat;

	spre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.cmd      (cmd),
		.in_ready (samples.ready)
	);

	spre_dpath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_valid       (samples.valid),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.sample_time    (samples.sample_time),
		.eta_value      (samples.eta_value),
		.out_valid      (results.valid),
		.out_ready      (results.ready),
		.filtered_valid (results.filtered_valid),
		.smooth_eta     (results.smooth_eta),
		.rate_valid     (results.rate_valid),
		.rate_value     (results.rate_value),
		.rate_error     (results.rate_error)
	);

endmodule

// ----- tb/tb_smoothed_progress_rate_estimator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_smoothed_progress_rate_estimator
// Feeds timestamped time-to-goal estimates through the sample channel and
// checks every filtered estimate and windowed progress rate against a
// scoreboard that tracks the filter, the ring of pairs and the smoothing
// weight. A directed opening covers seeding, saturated rates, zero and
// negative time steps and filter saturation. Random phases at several
// weights then follow, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_smoothed_progress_rate_estimator;

	localparam int RING_DEPTH = 8;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int NUM_PHASES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam longint ETA_MAX = 64'sh0000_0000_FFFF_FFFF;
	localparam longint RATE_MAX = 64'sd2147483647;
	localparam longint RATE_MIN = -64'sd2147483648;
	localparam logic [spre_pkg::TIME_W-1:0] TIME_MAX = '1;
	localparam logic [spre_pkg::ETA_W-1:0] ETA_ALL_ONES = '1;

	typedef struct {
		logic                        filtered_valid;
		logic [spre_pkg::ETA_W-1:0]  smooth_eta;
		logic                        rate_valid;
		logic [spre_pkg::RATE_W-1:0] rate_value;
		logic                        rate_error;
	} rate_result_t;

	class eta_rate_scoreboard;
		logic [spre_pkg::ALPHA_W-1:0] alpha;
		logic [spre_pkg::ETA_W-1:0]   ema;
		int                           fill;
		int                           wptr;
		logic [spre_pkg::TIME_W-1:0]  time_ring[RING_DEPTH];
		logic [spre_pkg::ETA_W-1:0]   eta_ring[RING_DEPTH];
		rate_result_t                 expected_results[$];
		int                           mismatches;

		function new();
			alpha = spre_pkg::ALPHA_RESET;
			ema = '0;
			fill = 0;
			wptr = 0;
			mismatches = 0;
			foreach (time_ring[i]) begin
				time_ring[i] = '0;
				eta_ring[i] = '0;
			end
		endfunction

		function void store_pair(logic [spre_pkg::TIME_W-1:0] t,
			logic [spre_pkg::ETA_W-1:0] f);
			time_ring[wptr] = t;
			eta_ring[wptr] = f;
			wptr = (wptr + 1) % RING_DEPTH;
			if (fill < RING_DEPTH)
				fill++;
		endfunction

		function logic [spre_pkg::TIME_W-1:0] oldest_time();
			return time_ring[wptr];
		endfunction

		function void note_sample(logic [spre_pkg::TIME_W-1:0] t,
			logic [spre_pkg::ETA_W-1:0] x);
			rate_result_t r;
			longint diff, nxt, num, den, q;
			logic [spre_pkg::ETA_W-1:0] f;
			r = '{default: '0};
			if (fill == 0) begin
				ema = x;
				store_pair(t, x);
			end else begin
				diff = longint'(x) - longint'(ema);
				nxt = longint'(ema) + ((longint'(alpha) * diff) >>> 16);
				if (nxt < 0)
					nxt = 0;
				if (nxt > ETA_MAX)
					nxt = ETA_MAX;
				f = nxt[spre_pkg::ETA_W-1:0];
				ema = f;
				r.filtered_valid = 1'b1;
				r.smooth_eta = f;
				if (fill >= RING_DEPTH) begin
					num = longint'(eta_ring[wptr]) - longint'(f);
					den = longint'(t) - longint'(time_ring[wptr]);
					r.rate_valid = 1'b1;
					if (den <= 0) begin
						r.rate_error = 1'b1;
					end else begin
						q = (num * 65536) / den;
						if (q > RATE_MAX)
							q = RATE_MAX;
						if (q < RATE_MIN)
							q = RATE_MIN;
						r.rate_value = q[spre_pkg::RATE_W-1:0];
					end
				end
				store_pair(t, f);
			end
			expected_results.push_back(r);
		endfunction

		function void report(string field, longint exp_v, longint got_v);
			mismatches++;
			if (mismatches <= 100)
				$display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
					$time, field, exp_v, exp_v, got_v, got_v);
		endfunction

		function void check_result(rate_result_t got);
			rate_result_t exp_r;
			if (expected_results.size() == 0) begin
				report("unexpected transaction, smooth_eta", -1, longint'(got.smooth_eta));
				return;
			end
			exp_r = expected_results.pop_front();
			if (got.filtered_valid !== exp_r.filtered_valid)
				report("filtered_valid", exp_r.filtered_valid, got.filtered_valid);
			if (got.smooth_eta !== exp_r.smooth_eta)
				report("smooth_eta", longint'(exp_r.smooth_eta), longint'(got.smooth_eta));
			if (got.rate_valid !== exp_r.rate_valid)
				report("rate_valid", exp_r.rate_valid, got.rate_valid);
			if (got.rate_value !== exp_r.rate_value)
				report("rate_value", longint'(signed'(exp_r.rate_value)),
					longint'(signed'(got.rate_value)));
			if (got.rate_error !== exp_r.rate_error)
				report("rate_error", exp_r.rate_error, got.rate_error);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [spre_pkg::ALPHA_W-1:0] cfg_wr_data;
	int cycles = 0;
	bit sender_steady;
	bit receiver_steady;
	eta_rate_scoreboard sb;

	spre_sample_if samples_ch ();
	spre_result_if results_ch ();

	smoothed_progress_rate_estimator #(
		.WINDOW_DEPTH(RING_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.samples    (samples_ch),
		.results    (results_ch)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic push_sample(logic [spre_pkg::TIME_W-1:0] t,
		logic [spre_pkg::ETA_W-1:0] x);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.sample_time <= t;
		samples_ch.eta_value <= x;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		sb.note_sample(t, x);
		@(negedge clk);
	endtask

	task automatic write_alpha(logic [spre_pkg::ALPHA_W-1:0] a);
		samples_ch.valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= a;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.alpha = a;
	endtask

	// result side: random stall per transaction, then accept and check
	initial begin
		int stall;
		rate_result_t got;
		results_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = receiver_steady ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				results_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			results_ch.ready <= 1'b1;
			@(posedge clk);
			while (!results_ch.valid)
				@(posedge clk);
			got.filtered_valid = results_ch.filtered_valid;
			got.smooth_eta = results_ch.smooth_eta;
			got.rate_valid = results_ch.rate_valid;
			got.rate_value = results_ch.rate_value;
			got.rate_error = results_ch.rate_error;
			sb.check_result(got);
			@(negedge clk);
		end
	end

	initial begin
		logic [spre_pkg::ALPHA_W-1:0] alpha_plan[NUM_PHASES];
		logic [spre_pkg::TIME_W-1:0] t;
		logic [spre_pkg::ETA_W-1:0] x;
		logic [spre_pkg::TIME_W-1:0] last_t;
		logic [spre_pkg::ETA_W-1:0] last_x;
		int mode;

		sb = new();
		sender_steady = 1'b0;
		receiver_steady = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = spre_pkg::ALPHA_RESET;
		samples_ch.valid = 1'b0;
		samples_ch.sample_time = '0;
		samples_ch.eta_value = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// seed, then one update at the reset weight
		push_sample(48'd0, 32'd0);
		push_sample(48'd1, ETA_ALL_ONES);

		// no smoothing: fill the ring with alternating extremes
		write_alpha(17'd65536);
		push_sample(48'd2, 32'd0);
		push_sample(48'd3, ETA_ALL_ONES);
		push_sample(48'd4, 32'd0);
		push_sample(48'd5, ETA_ALL_ONES);
		push_sample(48'd6, 32'd0);
		push_sample(48'd7, ETA_ALL_ONES);
		push_sample(48'd8, ETA_ALL_ONES);
		push_sample(48'd9, 32'd0);
		push_sample(48'd2, 32'd0);
		push_sample(48'd0, 32'd0);
		push_sample(TIME_MAX, ETA_ALL_ONES);
		push_sample(48'h8000_0000_0000, 32'h8000_0000);

		// filter frozen
		write_alpha(17'd0);
		push_sample(48'h8000_0001_0000, ETA_ALL_ONES);
		push_sample(48'h8000_0002_0000, 32'd0);
		push_sample(48'h8000_0003_0000, 32'h1234_5678);

		// weight above one: drive the filter into both saturation limits
		write_alpha(17'h1FFFF);
		push_sample(48'h8000_0004_0000, 32'd0);
		push_sample(48'h8000_0005_0000, 32'd0);
		push_sample(48'h8000_0006_0000, ETA_ALL_ONES);
		push_sample(48'h8000_0007_0000, ETA_ALL_ONES);

		alpha_plan[0] = 17'd65536;
		alpha_plan[1] = 17'd0;
		alpha_plan[2] = 17'd1;
		alpha_plan[3] = 17'd32768;
		alpha_plan[4] = 17'($urandom_range(0, 65536));
		alpha_plan[5] = spre_pkg::ALPHA_RESET;
		alpha_plan[6] = 17'h1FFFF;
		alpha_plan[7] = 17'($urandom_range(0, 65536));

		last_t = 48'h8000_0007_0000;
		last_x = ETA_ALL_ONES;
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_alpha(alpha_plan[p]);
			sender_steady = (p == 2 || p == 5);
			receiver_steady = (p == 2 || p == 6);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				mode = $urandom_range(0, 99);
				t = last_t + spre_pkg::TIME_W'($urandom_range(1, 1 << 18));
				x = last_x + spre_pkg::ETA_W'($urandom_range(0, 1 << 20))
					- spre_pkg::ETA_W'(1 << 19);
				if (mode >= 75 && mode < 85)
					x = $urandom;
				else if (mode >= 85 && mode < 88)
					t = sb.oldest_time();
				else if (mode >= 88 && mode < 91)
					t = sb.oldest_time() - spre_pkg::TIME_W'($urandom_range(1, 1 << 16));
				else if (mode >= 91 && mode < 96)
					t = {16'($urandom), 32'($urandom)};
				else if (mode >= 96)
					x = mode[0] ? ETA_ALL_ONES : '0;
				push_sample(t, x);
				last_t = t;
				last_x = x;
			end
		end

		samples_ch.valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- smoothed_progress_rate_estimator.f -----
+incdir+rtl
rtl/spre_pkg.sv
rtl/spre_sample_if.sv
rtl/spre_result_if.sv
rtl/spre_dpath.sv
rtl/spre_ctrl.sv
rtl/smoothed_progress_rate_estimator.sv
tb/tb_smoothed_progress_rate_estimator.sv
